FILE: rtl/sfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_pkg
// shared types and constants of the stereo feedback echo
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int GAIN_BITS     = 16;
    localparam int LENGTH_BITS   = 13;
    localparam int CHANNEL_BITS  = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // channel count codes
    localparam logic [CHANNEL_BITS-1:0] CHAN_NONE = 2'd0;
    localparam logic [CHANNEL_BITS-1:0] CHAN_LEFT = 2'd1;

    localparam logic [LENGTH_BITS-1:0]  LENGTH_RESET  = 13'd4096;
    localparam logic [GAIN_BITS-1:0]    GAIN_RESET    = 16'd32768;
    localparam logic [CHANNEL_BITS-1:0] CHANNEL_RESET = 2'd2;

    // delay line control from the top level to one channel
    typedef struct packed {
        logic rd_en;   // item accepted, read the entry at the pointer
        logic wr_en;   // item leaves the compute stage, write the result back
        logic clr;     // post-reset clearing pass
    } t_chan_ctrl;

endpackage
`default_nettype wire

FILE: rtl/sfe_channel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_channel
// one echo channel: delay memory, write-back bypass, scale, add and saturate
// ----------------------------------------------------------------------------
module sfe_channel #(
    parameter int DELAY_DEPTH = sfe_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire sfe_pkg::t_chan_ctrl              i_ctrl,
    input  wire [$clog2(DELAY_DEPTH)-1:0]         i_rd_addr,
    input  wire [$clog2(DELAY_DEPTH)-1:0]         i_wr_addr,
    input  wire [$clog2(DELAY_DEPTH)-1:0]         i_clr_addr,
    input  wire signed [SAMPLE_BITS-1:0]          i_sample,
    input  wire [sfe_pkg::GAIN_BITS-1:0]          i_gain,
    output logic signed [SAMPLE_BITS-1:0]         o_result
);
    import sfe_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int SW = SAMPLE_BITS + 2;

    localparam logic signed [SW-1:0] SAT_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] r_mem [DELAY_DEPTH];
    logic [SAMPLE_BITS-1:0] r_mem_q;
    logic [SAMPLE_BITS-1:0] r_byp_val;
    logic                   r_byp_sel;

    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          rounded;
    logic signed [SAMPLE_BITS:0]   scaled;
    logic signed [SW-1:0]          sum;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_mem[i_clr_addr] <= '0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= o_result;
        end
        if (i_ctrl.rd_en) begin
            r_mem_q   <= r_mem[i_rd_addr];
            r_byp_val <= o_result;
            // the entry is being written back at the same edge it is read
            r_byp_sel <= i_ctrl.wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_comb begin
        delayed = r_byp_sel ? $signed(r_byp_val) : $signed(r_mem_q);
        prod    = PW'(delayed) * $signed({1'b0, i_gain});
        // round half up, then drop the 16 fraction bits
        rounded = prod + PW'(1 << (GAIN_BITS-1));
        scaled  = rounded[PW-1:GAIN_BITS];
        sum     = SW'(scaled) + SW'(i_sample);
        if (sum > SAT_MAX) begin
            o_result = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (sum < SAT_MIN) begin
            o_result = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_result = sum[SAMPLE_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/stereo_feedback_echo_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_echo_top
// stereo feedback comb-filter echo with a shared circular write pointer
// ----------------------------------------------------------------------------
// item path: memory read on accept, then compute stage into the output register
// throughput: one item per cycle unless output stalls, one multiply per channel
// reset: after i_rst_n both delay memories are swept to zero, one entry per
//   cycle, DELAY_DEPTH entries (4096 by default); o_in_ready is low meanwhile
// configuration writes are accepted at any time, including during the sweep
module stereo_feedback_echo_top #(
    parameter int DELAY_DEPTH = sfe_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = sfe_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [sfe_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire [sfe_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,

    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire signed [SAMPLE_BITS-1:0]       i_left_in,
    input  wire signed [SAMPLE_BITS-1:0]       i_right_in,
    input  wire                                i_block_end,

    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_left_out,
    output logic signed [SAMPLE_BITS-1:0]      o_right_out,
    output logic                               o_block_end_out
);
    import sfe_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int CW = (AW + 1 > LENGTH_BITS) ? AW + 1 : LENGTH_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

    // configuration
    logic [LENGTH_BITS-1:0]  r_delay_length;
    logic [GAIN_BITS-1:0]    r_feedback_gain;
    logic [CHANNEL_BITS-1:0] r_channel_count;

    // clearing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // pointer
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] ptr_inc;

    // compute stage
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_left;
    logic signed [SAMPLE_BITS-1:0] r_s1_right;
    logic                          r_s1_end;
    logic [AW-1:0]                 r_s1_ptr;
    logic                          r_s1_lact;
    logic                          r_s1_ract;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_end;

    logic in_fire;
    logic s1_move;
    logic chan_left;
    logic chan_right;

    t_chan_ctrl ctrl_l;
    t_chan_ctrl ctrl_r;
    logic signed [SAMPLE_BITS-1:0] res_l;
    logic signed [SAMPLE_BITS-1:0] res_r;

    assign o_cfg_ready = 1'b1;

    assign chan_left  = (r_channel_count != CHAN_NONE);
    assign chan_right = (r_channel_count != CHAN_NONE) && (r_channel_count != CHAN_LEFT);

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || !r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        len_ext = CW'(r_delay_length);
        if (len_ext == '0) begin
            len_eff = CW'(1);
        end else if (len_ext > DEPTH_C) begin
            len_eff = DEPTH_C;
        end else begin
            len_eff = len_ext;
        end
        ptr_inc = CW'(r_ptr) + CW'(1);
        n_ptr   = (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];
    end

    always_comb begin
        ctrl_l.rd_en = in_fire;
        ctrl_l.wr_en = s1_move && r_s1_lact;
        ctrl_l.clr   = r_clearing;
        ctrl_r.rd_en = in_fire;
        ctrl_r.wr_en = s1_move && r_s1_ract;
        ctrl_r.clr   = r_clearing;
    end

    sfe_channel #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl_l),
        .i_rd_addr  (r_ptr),
        .i_wr_addr  (r_s1_ptr),
        .i_clr_addr (r_clr_addr),
        .i_sample   (r_s1_left),
        .i_gain     (r_feedback_gain),
        .o_result   (res_l)
    );

    sfe_channel #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl_r),
        .i_rd_addr  (r_ptr),
        .i_wr_addr  (r_s1_ptr),
        .i_clr_addr (r_clr_addr),
        .i_sample   (r_s1_right),
        .i_gain     (r_feedback_gain),
        .o_result   (res_r)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= LENGTH_RESET;
            r_feedback_gain <= GAIN_RESET;
            r_channel_count <= CHANNEL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data[LENGTH_BITS-1:0];
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[GAIN_BITS-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHANNEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clearing sweep and pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_ptr      <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_fire && chan_left) begin
                r_ptr <= n_ptr;
            end
        end
    end

    // compute stage and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_left  <= i_left_in;
            r_s1_right <= i_right_in;
            r_s1_end   <= i_block_end;
            r_s1_ptr   <= r_ptr;
            r_s1_lact  <= chan_left;
            r_s1_ract  <= chan_right;
        end
        if (s1_move) begin
            r_out_left  <= r_s1_lact ? res_l : r_s1_left;
            r_out_right <= r_s1_ract ? res_r : r_s1_right;
            r_out_end   <= r_s1_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_out_left;
    assign o_right_out     = r_out_right;
    assign o_block_end_out = r_out_end;

endmodule
`default_nettype wire
